### src/rspe_pkg.sv
package rspe_pkg;

  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] PARITY_RESET = 5'd10;
  localparam logic [CNT_W-1:0] PARITY_MIN   = 5'd2;
  // low byte of the field polynomial 0x11D
  localparam logic [7:0] FIELD_POLY_LO = 8'h1D;
  localparam logic [7:0] ALPHA = 8'h02;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_end;
  } rspe_in_t;

  typedef struct packed {
    logic [7:0]       parity_byte;
    logic [CNT_W-1:0] parity_position;
    logic             run_last;
  } rspe_out_t;

  // remainder register control
  typedef struct packed {
    logic step;
    logic clear;
  } rspe_step_t;

  // parity buffer load control
  typedef struct packed {
    logic             load;
    logic [CNT_W-1:0] count;
  } rspe_load_t;

  // GF(256) multiply, shift and add with reduction
  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] sh;
    acc = '0;
    sh  = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc = acc ^ sh;
      sh = {sh[6:0], 1'b0} ^ (sh[7] ? FIELD_POLY_LO : 8'h00);
    end
    return acc;
  endfunction

endpackage

### src/reed_solomon_parity_encoder_top.sv
// Reed-Solomon parity encoder, GF(256), field polynomial 0x11D (QR code).
// Input channel (in_valid/in_ready/in_data): one message byte per transfer,
// block_end set on the last byte of a block. Bytes are absorbed at one per
// cycle, back to back, across block boundaries.
// Output channel (out_valid/out_ready/out_data): after a block_end byte the
// block emits parity_count parity bytes, highest-order coefficient first,
// with parity_position counting from 0 and run_last on the final one.
// With the parity buffer free, a block_end byte passes from the input
// register into the parity buffer, whose first byte is then valid; the
// run then drains at one byte per cycle while out_ready holds.
// The next block's message bytes keep flowing while a run drains; only a
// further block_end byte waits until the parity buffer is free.
// A stalled receiver holds the current parity byte; the message side stalls
// only at its next block_end.
// Config channel (cfg_valid/cfg_ready/cfg_data): always ready; sets the parity
// count, clamped to 2..MAX_PARITY, and picks the generator row from a
// constant table. Write only while the block is idle.
// Reset: remainder cleared, no run pending, parity count 10.
module reed_solomon_parity_encoder_top import rspe_pkg::*; #(
  parameter int MAX_PARITY = 30
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rspe_in_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rspe_out_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  localparam int ROW_W    = MAX_PARITY * 8;
  localparam int TBL_ROWS = 2 ** CNT_W;

  // generator coefficients without the leading 1, one row per degree
  function automatic logic [TBL_ROWS*ROW_W-1:0] build_gen_table();
    logic [TBL_ROWS*ROW_W-1:0] tbl;
    logic [7:0]                poly [TBL_ROWS];
    logic [7:0]                root;
    tbl  = '0;
    root = 8'h01;
    for (int j = 0; j < TBL_ROWS; j++) poly[j] = 8'h00;
    poly[0] = 8'h01;
    for (int k = 0; k < TBL_ROWS - 1; k++) begin
      for (int j = k + 1; j >= 1; j--) poly[j] = poly[j] ^ gf_mul(poly[j-1], root);
      for (int j = 1; j <= k + 1; j++) begin
        if (j - 1 < MAX_PARITY) tbl[(k+1)*ROW_W + (j-1)*8 +: 8] = poly[j];
      end
      root = gf_mul(root, ALPHA);
    end
    return tbl;
  endfunction

  localparam logic [TBL_ROWS*ROW_W-1:0] GEN_TABLE = build_gen_table();

  function automatic logic [CNT_W-1:0] clamp_count(logic [CNT_W-1:0] v);
    if (v < PARITY_MIN) return PARITY_MIN;
    if (int'(v) > MAX_PARITY) return CNT_W'(MAX_PARITY);
    return v;
  endfunction

  // configuration: effective degree and its generator row
  logic [CNT_W-1:0] n_sel;
  logic [CNT_W-1:0] n_r;
  logic [ROW_W-1:0] coef_row;

  assign cfg_ready = 1'b1;
  assign n_sel     = clamp_count(rst ? PARITY_RESET : cfg_data);

  always_ff @(posedge clk) begin
    if (rst || cfg_valid) begin
      n_r      <= n_sel;
      coef_row <= GEN_TABLE[n_sel*ROW_W +: ROW_W];
    end
  end

  // input register
  logic       in_v;
  rspe_in_t   in_r;
  logic       free;
  logic       adv;

  assign adv      = in_v && (!in_r.block_end || free);
  assign in_ready = !in_v || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_v <= 1'b1;
      in_r <= in_data;
    end else if (adv) begin
      in_v <= 1'b0;
    end
  end

  rspe_step_t       step_ctl;
  rspe_load_t       load_ctl;
  logic [ROW_W-1:0] rem_next;

  assign step_ctl.step  = adv;
  assign step_ctl.clear = in_r.block_end;
  assign load_ctl.load  = adv && in_r.block_end;
  assign load_ctl.count = n_r;

  rspe_lfsr #(
    .MAX_PARITY(MAX_PARITY)
  ) u_lfsr (
    .clk      (clk),
    .rst      (rst),
    .ctl      (step_ctl),
    .data_byte(in_r.data_byte),
    .n        (n_r),
    .coef     (coef_row),
    .rem_next (rem_next)
  );

  rspe_drain #(
    .MAX_PARITY(MAX_PARITY)
  ) u_drain (
    .clk      (clk),
    .rst      (rst),
    .ctl      (load_ctl),
    .load_data(rem_next),
    .free     (free),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

`ifndef SYNTH
  a_degree_range: assert property (@(posedge clk) disable iff (rst)
    (n_r >= PARITY_MIN) && (int'(n_r) <= MAX_PARITY))
    else $error("effective parity count out of range");
`endif

endmodule

### src/rspe_lfsr.sv
module rspe_lfsr import rspe_pkg::*; #(
  parameter int MAX_PARITY = 30
) (
  input  logic                    clk,
  input  logic                    rst,
  input  rspe_step_t              ctl,
  input  logic [7:0]              data_byte,
  input  logic [CNT_W-1:0]        n,
  input  logic [MAX_PARITY*8-1:0] coef,
  output logic [MAX_PARITY*8-1:0] rem_next
);

  logic [MAX_PARITY*8-1:0] rem;
  logic [7:0]              fb;

  assign fb = data_byte ^ rem[7:0];

  // one division step; bytes at and beyond the degree keep their values
  always_comb begin
    for (int i = 0; i < MAX_PARITY; i++) begin
      if (i + 1 < int'(n)) begin
        if (i + 1 < MAX_PARITY) begin
          rem_next[i*8 +: 8] = rem[(i+1)*8 +: 8] ^ gf_mul(fb, coef[i*8 +: 8]);
        end else begin
          rem_next[i*8 +: 8] = gf_mul(fb, coef[i*8 +: 8]);
        end
      end else if (i + 1 == int'(n)) begin
        rem_next[i*8 +: 8] = gf_mul(fb, coef[i*8 +: 8]);
      end else begin
        rem_next[i*8 +: 8] = rem[i*8 +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (ctl.step) begin
      rem <= ctl.clear ? '0 : rem_next;
    end
  end

endmodule

### src/rspe_drain.sv
module rspe_drain import rspe_pkg::*; #(
  parameter int MAX_PARITY = 30
) (
  input  logic                    clk,
  input  logic                    rst,
  input  rspe_load_t              ctl,
  input  logic [MAX_PARITY*8-1:0] load_data,
  output logic                    free,
  output logic                    out_valid,
  input  logic                    out_ready,
  output rspe_out_t               out_data
);

  localparam int ROW_W = MAX_PARITY * 8;

  logic [ROW_W-1:0] pbuf;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] pos;

  assign out_valid                = (count != '0);
  assign out_data.parity_byte     = pbuf[7:0];
  assign out_data.parity_position = pos;
  assign out_data.run_last        = (count == CNT_W'(1));
  assign free = (count == '0) || ((count == CNT_W'(1)) && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pos   <= '0;
    end else if (ctl.load) begin
      pbuf  <= load_data;
      count <= ctl.count;
      pos   <= '0;
    end else if (out_valid && out_ready) begin
      pbuf  <= pbuf >> 8;
      count <= count - CNT_W'(1);
      pos   <= pos + CNT_W'(1);
    end
  end

`ifndef SYNTH
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    ctl.load |-> free)
    else $error("parity buffer loaded while busy");
  a_load_count: assert property (@(posedge clk) disable iff (rst)
    ctl.load |=> (count == $past(ctl.count)) && (pos == '0))
    else $error("parity run length not taken on load");
  a_run_span: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (int'(pos) + int'(count) <= MAX_PARITY))
    else $error("parity run exceeds buffer depth");
`endif

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rspe_pkg::*;

  localparam int MAX_PARITY = 30;
  // receiver hold-off, long enough for the encoder to back up into its input
  localparam int HOLD_CYCLES = 200;
  // quiet cycles after the last parity byte before a config write or the end
  localparam int SETTLE_CYCLES = 8;
  // cycles with no transfer on any channel before the run is declared hung
  localparam int HANG_LIMIT = 2000;
  localparam int REPORT_MAX = 10;

  // Parity predictor and checker. Keeps its own copy of the remainder LFSR
  // and the parity count; every block_end byte queues the parity run.
  class parity_scoreboard;
    logic [7:0] antilog [0:254];
    logic [7:0] logtab [0:255];
    // gen_rows[n] holds g(x) of degree n without the leading 1
    logic [7:0] gen_rows [0:MAX_PARITY][0:MAX_PARITY-1];
    logic [7:0] remainder [0:MAX_PARITY-1];
    logic [CNT_W-1:0] count_reg;
    rspe_out_t parity_due [$];
    int errors;

    function new();
      int v;
      int i;
      int k;
      int j;
      logic [7:0] poly [0:MAX_PARITY];
      v = 1;
      for (i = 0; i < 255; i++) begin
        antilog[i] = v[7:0];
        logtab[v] = i[7:0];
        v = v << 1;
        if (v & 'h100) v = v ^ 'h11D;
      end
      logtab[0] = 8'h00;
      for (i = 0; i <= MAX_PARITY; i++) begin
        poly[i] = 8'h00;
        for (j = 0; j < MAX_PARITY; j++) gen_rows[i][j] = 8'h00;
      end
      poly[0] = 8'h01;
      // running product of (x + alpha^k), highest order first
      for (k = 0; k < MAX_PARITY; k++) begin
        for (j = k + 1; j >= 1; j--) poly[j] = poly[j] ^ gf_mult(poly[j-1], antilog[k]);
        for (j = 1; j <= k + 1; j++) gen_rows[k+1][j-1] = poly[j];
      end
      for (i = 0; i < MAX_PARITY; i++) remainder[i] = 8'h00;
      count_reg = PARITY_RESET;
      errors = 0;
    endfunction

    function logic [7:0] gf_mult(logic [7:0] a, logic [7:0] b);
      int s;
      if (a == 8'h00 || b == 8'h00) return 8'h00;
      s = (int'(logtab[a]) + int'(logtab[b])) % 255;
      return antilog[s];
    endfunction

    function void set_count(logic [CNT_W-1:0] v);
      count_reg = v;
    endfunction

    function int pending();
      return parity_due.size();
    endfunction

    // one accepted message byte: clock the LFSR, queue parity on block_end
    function void note_byte(logic [7:0] d, logic e);
      int n;
      int i;
      logic [7:0] fb;
      rspe_out_t res;
      n = int'(count_reg);
      if (n < int'(PARITY_MIN)) n = int'(PARITY_MIN);
      if (n > MAX_PARITY) n = MAX_PARITY;
      fb = d ^ remainder[0];
      for (i = 0; i + 1 < n; i++) remainder[i] = remainder[i+1] ^ gf_mult(fb, gen_rows[n][i]);
      remainder[n-1] = gf_mult(fb, gen_rows[n][n-1]);
      if (e) begin
        for (i = 0; i < n; i++) begin
          res.parity_byte = remainder[i];
          res.parity_position = i[CNT_W-1:0];
          res.run_last = (i + 1 == n);
          parity_due = {parity_due, res};
        end
        for (i = 0; i < MAX_PARITY; i++) remainder[i] = 8'h00;
      end
    endfunction

    function void check_parity(rspe_out_t got);
      rspe_out_t want;
      if (parity_due.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("%0t: unexpected parity byte %02h pos %0d last %b", $realtime,
                   got.parity_byte, got.parity_position, got.run_last);
        return;
      end
      want = parity_due.pop_front();
      if (got.parity_byte !== want.parity_byte ||
          got.parity_position !== want.parity_position ||
          got.run_last !== want.run_last) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("%0t: mismatch byte exp %02h got %02h, pos exp %0d got %0d, last exp %b got %b",
                   $realtime, want.parity_byte, got.parity_byte, want.parity_position,
                   got.parity_position, want.run_last, got.run_last);
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  rspe_in_t         in_data;
  logic             out_valid;
  logic             out_ready;
  rspe_out_t        out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data;

  parity_scoreboard sb;
  logic hold_req;   // main sequence asks the receiver for a long hold-off
  logic burst;      // current block goes out with no sender gaps
  int   items_sent;

  reed_solomon_parity_encoder_top #(.MAX_PARITY(MAX_PARITY)) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 45);
  endfunction

  // Offer one message byte; valid stays high afterwards so back-to-back
  // transfers need no extra edge. Inputs move on the falling edge only.
  task automatic send_byte(input logic [7:0] d, input logic e);
    int gap;
    gap = burst ? 0 : idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: d, block_end: e};
    do @(posedge clk); while (!in_ready);
    sb.note_byte(d, e);
    items_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Random block, content weighted a bit toward 00 and FF.
  task automatic send_block(input int len);
    int k;
    int r;
    logic [7:0] d;
    burst = ($urandom_range(0, 3) == 0);
    for (k = 0; k < len; k++) begin
      r = $urandom_range(0, 99);
      d = (r < 8) ? 8'h00 : (r < 16) ? 8'hFF : 8'($urandom_range(0, 255));
      send_byte(d, k == len - 1);
    end
    burst = 1'b0;
  endtask

  // Sender stands still until the parity run has fully drained.
  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [CNT_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_count(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Output monitor: every parity transfer goes to the checker.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_parity(out_data);
  end

  // Receiver: random ready runs and stalls, plus the requested long hold-off.
  initial begin : receiver
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if ($urandom_range(0, 99) < 60) begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(40, 80)) @(negedge clk);
        else repeat ($urandom_range(1, 24)) @(negedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat (idle_len() + 1) @(negedge clk);
      end
    end
  end

  // Hang detector: counts cycles without any transfer on any channel.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    while (quiet < HANG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int p;
    int r;
    int blk_len;
    int target;
    logic [CNT_W-1:0] phase_cfg [0:3];
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    hold_req   = 1'b0;
    burst      = 1'b0;
    items_sent = 0;
    sb = new();
    rst = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // --- directed, reset parity count of 10 ---
    // zero message: zero feedback throughout, all-zero parity
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    stop_sending();
    wait_idle();

    // 31 clamps to the maximum of 30
    write_count(5'd31);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b1);
    stop_sending();
    wait_idle();

    // 0 and 1 both clamp to the minimum of 2
    write_count(5'd0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b1);
    stop_sending();
    wait_idle();
    write_count(5'd1);
    send_byte(8'hFF, 1'b1);
    stop_sending();
    wait_idle();

    // count shrinks mid-block: upper remainder bytes are left as they are
    write_count(5'd16);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'h7E, 1'b0);
    stop_sending();
    wait_idle();
    write_count(5'd5);
    send_byte(8'h81, 1'b0);
    send_byte(8'h42, 1'b1);
    stop_sending();
    wait_idle();

    // count grows mid-block
    write_count(5'd3);
    send_byte(8'h99, 1'b0);
    send_byte(8'h66, 1'b0);
    stop_sending();
    wait_idle();
    write_count(5'd20);
    send_byte(8'hE7, 1'b1);
    stop_sending();

    // --- random phases; the first one runs under a long receiver hold-off ---
    phase_cfg[0] = 5'd30;
    phase_cfg[1] = 5'd2;
    phase_cfg[2] = CNT_W'($urandom_range(3, 29));
    phase_cfg[3] = CNT_W'($urandom_range(0, 31));
    for (p = 0; p < 4; p++) begin
      wait_idle();
      write_count(phase_cfg[p]);
      if (p == 0) hold_req = 1'b1;
      target = items_sent + 35;
      while (items_sent < target) begin
        r = $urandom_range(0, 99);
        blk_len = (r < 10) ? 1 : (r < 80) ? $urandom_range(2, 10) : $urandom_range(11, 40);
        if (blk_len > target - items_sent) blk_len = target - items_sent;
        send_block(blk_len);
      end
      stop_sending();
    end

    wait_idle();
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
